[rtl/ofip_pkg.sv]
// ofip_pkg: shared constants and types for the face index parser
// character codes, status codes and the flag group passed from core to top
// depends on nothing
package ofip_pkg;

    // character codes seen in the text stream
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_F       = 8'h66;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MANY = 2'd1;
    localparam logic [1:0] STATUS_FEW  = 2'd2;

    localparam int CORNER_BITS = 3;
    localparam int STATUS_BITS = 2;

    // control group of one emitted reference
    typedef struct packed {
        logic                   emit;
        logic                   last;
        logic [STATUS_BITS-1:0] status;
        logic [CORNER_BITS-1:0] corner;
    } ofip_flags_t;

endpackage

[rtl/ofip_core.sv]
// ofip_core: line and reference parser state for the face index parser
// updates on each accepted byte and gives at most one reference per byte
// depends on ofip_pkg
module ofip_core
    import ofip_pkg::*;
#(
    parameter int INDEX_BITS        = 24,
    parameter int VERTEX_COUNT_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [7:0]                   text_byte,
    output ofip_flags_t                  flags,
    output logic [INDEX_BITS:0]          position_index,
    output logic [INDEX_BITS:0]          texcoord_index,
    output logic [INDEX_BITS:0]          normal_index,
    output logic [VERTEX_COUNT_BITS-1:0] output_vertex
);

    localparam int IW = INDEX_BITS + 1;
    localparam int MW = INDEX_BITS + 4;

    // parse phase codes
    localparam logic [1:0] PH_KEY  = 2'd0;
    localparam logic [1:0] PH_FACE = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    localparam logic [1:0] SLOT_POS = 2'd0;
    localparam logic [1:0] SLOT_TEX = 2'd1;
    localparam logic [1:0] SLOT_NRM = 2'd2;
    localparam logic [1:0] SLOT_END = 2'd3;

    localparam logic [IW-1:0] IDX_NONE = {IW{1'b1}};
    localparam logic [IW-1:0] IDX_ONE  = {{INDEX_BITS{1'b0}}, 1'b1};

    logic [1:0]                   phase_reg, phase_next;
    logic                         kw_face_reg, kw_face_next;
    logic [1:0]                   kw_len_reg, kw_len_next;
    logic [INDEX_BITS-1:0]        acc_reg, acc_next;
    logic [1:0]                   slot_reg, slot_next;
    logic [IW-1:0]                hpos_reg, hpos_next;
    logic [IW-1:0]                htex_reg, htex_next;
    logic [IW-1:0]                hnrm_reg, hnrm_next;
    logic                         in_ref_reg, in_ref_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [IW-1:0]                ppos_reg, ppos_next;
    logic [IW-1:0]                ptex_reg, ptex_next;
    logic [IW-1:0]                pnrm_reg, pnrm_next;
    logic [CORNER_BITS-1:0]       corner_reg, corner_next;
    logic [VERTEX_COUNT_BITS-1:0] vtotal_reg, vtotal_next;

    logic                  is_nl, is_space, is_slash, is_digit;
    logic [INDEX_BITS-1:0] b_acc;
    logic [1:0]            b_slot;
    logic [IW-1:0]         b_hpos, b_htex, b_hnrm;
    logic [IW-1:0]         part_cur, part_base;
    logic [IW-1:0]         fin_pos, fin_tex, fin_nrm;
    logic [MW-1:0]         acc_wide, acc_mul;
    logic                  emit, emit_last;
    logic [IW-1:0]         e_pos, e_tex, e_nrm;

    // byte classes
    assign is_nl    = (text_byte == CHAR_NEWLINE);
    assign is_space = (text_byte == CHAR_SPACE);
    assign is_slash = (text_byte == CHAR_SLASH);
    assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);

    // state a new reference starts from
    assign b_acc  = in_ref_reg ? acc_reg  : '0;
    assign b_slot = in_ref_reg ? slot_reg : SLOT_POS;
    assign b_hpos = in_ref_reg ? hpos_reg : '0;
    assign b_htex = in_ref_reg ? htex_reg : IDX_NONE;
    assign b_hnrm = in_ref_reg ? hnrm_reg : IDX_NONE;

    // written number minus one, zero or empty gives -1
    assign part_cur  = {1'b0, acc_reg} - IDX_ONE;
    assign part_base = {1'b0, b_acc} - IDX_ONE;

    // indices of the reference that ends now
    assign fin_pos = (slot_reg == SLOT_POS) ? part_cur : hpos_reg;
    assign fin_tex = (slot_reg == SLOT_TEX) ? part_cur : htex_reg;
    assign fin_nrm = (slot_reg == SLOT_NRM) ? part_cur : hnrm_reg;

    // decimal shift-add: acc * 8 + acc * 2 + digit
    assign acc_wide = {4'b0000, b_acc};
    assign acc_mul  = (acc_wide << 3) + (acc_wide << 1)
                    + {{INDEX_BITS{1'b0}}, text_byte[3:0]};

    // next state and emitted reference
    always_comb
    begin
        phase_next      = phase_reg;
        kw_face_next    = kw_face_reg;
        kw_len_next     = kw_len_reg;
        acc_next        = acc_reg;
        slot_next       = slot_reg;
        hpos_next       = hpos_reg;
        htex_next       = htex_reg;
        hnrm_next       = hnrm_reg;
        in_ref_next     = in_ref_reg;
        pend_valid_next = pend_valid_reg;
        ppos_next       = ppos_reg;
        ptex_next       = ptex_reg;
        pnrm_next       = pnrm_reg;
        corner_next     = corner_reg;
        vtotal_next     = vtotal_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        e_pos           = ppos_reg;
        e_tex           = ptex_reg;
        e_nrm           = pnrm_reg;

        if (accept)
        begin
            if (is_nl)
            begin
                if (phase_reg == PH_FACE)
                begin
                    if (in_ref_reg)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        e_pos     = fin_pos;
                        e_tex     = fin_tex;
                        e_nrm     = fin_nrm;
                    end
                    else if (pend_valid_reg)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
                phase_next      = PH_KEY;
                kw_face_next    = 1'b0;
                kw_len_next     = 2'd0;
                in_ref_next     = 1'b0;
                pend_valid_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_KEY:
                    begin
                        if (is_space)
                        begin
                            phase_next = (kw_len_reg == 2'd1 && kw_face_reg) ? PH_FACE
                                                                            : PH_SKIP;
                        end
                        else
                        begin
                            if (kw_len_reg == 2'd0 && text_byte == CHAR_F)
                            begin
                                kw_face_next = 1'b1;
                            end
                            if (kw_len_reg != 2'd2)
                            begin
                                kw_len_next = kw_len_reg + 2'd1;
                            end
                        end
                    end
                    PH_FACE:
                    begin
                        if (is_digit || is_slash)
                        begin
                            // first byte of a reference releases the pending one
                            if (!in_ref_reg && pend_valid_reg)
                            begin
                                emit            = 1'b1;
                                pend_valid_next = 1'b0;
                            end
                            in_ref_next = 1'b1;
                            acc_next    = b_acc;
                            slot_next   = b_slot;
                            hpos_next   = b_hpos;
                            htex_next   = b_htex;
                            hnrm_next   = b_hnrm;
                            if (is_slash)
                            begin
                                case (b_slot)
                                    SLOT_POS: hpos_next = part_base;
                                    SLOT_TEX: htex_next = part_base;
                                    SLOT_NRM: hnrm_next = part_base;
                                    default:  ;
                                endcase
                                if (b_slot != SLOT_END)
                                begin
                                    slot_next = b_slot + 2'd1;
                                end
                                acc_next = '0;
                            end
                            else if (b_slot != SLOT_END)
                            begin
                                // saturate at the largest accumulator value
                                acc_next = (|acc_mul[MW-1:INDEX_BITS]) ? {INDEX_BITS{1'b1}}
                                                                      : acc_mul[INDEX_BITS-1:0];
                            end
                        end
                        else if (in_ref_reg)
                        begin
                            // separator ends the reference, hold it as pending
                            ppos_next       = fin_pos;
                            ptex_next       = fin_tex;
                            pnrm_next       = fin_nrm;
                            pend_valid_next = 1'b1;
                            in_ref_next     = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // counters advance on every emitted reference, the corner count saturating at its top value
        if (emit)
        begin
            if (corner_reg != {CORNER_BITS{1'b1}})
            begin
                corner_next = corner_reg + {{(CORNER_BITS-1){1'b0}}, 1'b1};
            end
            vtotal_next = vtotal_reg + {{(VERTEX_COUNT_BITS-1){1'b0}}, 1'b1};
        end
        if (accept && is_nl)
        begin
            corner_next = '0;
        end
    end

    // result of this byte
    always_comb
    begin
        flags.emit   = emit;
        flags.last   = emit_last;
        flags.corner = corner_reg;
        if (corner_reg >= 3'd4)
        begin
            flags.status = STATUS_MANY;
        end
        else if (emit_last && corner_reg < 3'd2)
        begin
            flags.status = STATUS_FEW;
        end
        else
        begin
            flags.status = STATUS_OK;
        end
    end

    assign position_index = e_pos;
    assign texcoord_index = e_tex;
    assign normal_index   = e_nrm;
    assign output_vertex  = vtotal_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_KEY;
            kw_face_reg    <= 1'b0;
            kw_len_reg     <= 2'd0;
            slot_reg       <= SLOT_POS;
            in_ref_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            corner_reg     <= '0;
            vtotal_reg     <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            kw_face_reg    <= kw_face_next;
            kw_len_reg     <= kw_len_next;
            slot_reg       <= slot_next;
            in_ref_reg     <= in_ref_next;
            pend_valid_reg <= pend_valid_next;
            corner_reg     <= corner_next;
            vtotal_reg     <= vtotal_next;
        end
    end

    // reference payload, only read once a reference has started
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        hpos_reg <= hpos_next;
        htex_reg <= htex_next;
        hnrm_reg <= hnrm_next;
        ppos_reg <= ppos_next;
        ptex_reg <= ptex_next;
        pnrm_reg <= pnrm_next;
    end

endmodule

[rtl/obj_face_index_parser.sv]
// obj_face_index_parser: face line parser for model text
// top level with stream ports and the result register
// depends on ofip_pkg and ofip_core
//
// usage
//   s_axis carries model text, one byte per item in s_axis_tdata
//   m_axis carries one item per vertex reference of a face line:
//   zero-based position, texture and normal indices (-1 when absent),
//   corner number and running vertex number in tdata, face end in tlast,
//   status in tuser (0 ok, 1 more than four corners, 2 fewer than three)
//   a reference goes out when the byte after it is taken: the first byte of
//   the next reference, or the newline that closes the line
//   throughput is one byte per cycle while s_axis_tready is high; the result
//   of a byte is on m_axis from the cycle after it is taken, set by
//   the single result register behind the parser logic
//   when the receiver stalls with a result waiting, s_axis_tready goes low
//   until that result is taken; nothing is dropped
//   reset clears the parser to the start of a line, the vertex count to
//   zero and empties the result register
module obj_face_index_parser
    import ofip_pkg::*;
#(
    parameter int INDEX_BITS        = 24,
    parameter int VERTEX_COUNT_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,  // text_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // position_index, texcoord_index, normal_index, corner, output_vertex
    output logic [((3*(INDEX_BITS+1)+CORNER_BITS+VERTEX_COUNT_BITS+7)/8)*8-1:0]
                                                  m_axis_tdata,
    output logic                                  m_axis_tlast,  // face_last
    output logic [STATUS_BITS-1:0]                m_axis_tuser   // status
);

    localparam int IW     = INDEX_BITS + 1;
    localparam int RAW_W  = 3 * IW + CORNER_BITS + VERTEX_COUNT_BITS;
    localparam int DATA_W = ((RAW_W + 7) / 8) * 8;

    logic                         accept;
    ofip_flags_t                  flags;
    logic [IW-1:0]                pos, tex, nrm;
    logic [VERTEX_COUNT_BITS-1:0] vtx;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic                   out_last_reg;
    logic [STATUS_BITS-1:0] out_user_reg;

    // take a byte whenever the result register is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ofip_core #(
        .INDEX_BITS        (INDEX_BITS),
        .VERTEX_COUNT_BITS (VERTEX_COUNT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .text_byte      (s_axis_tdata),
        .flags          (flags),
        .position_index (pos),
        .texcoord_index (tex),
        .normal_index   (nrm),
        .output_vertex  (vtx)
    );

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= flags.emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && flags.emit)
        begin
            out_data_reg <= {{(DATA_W-RAW_W){1'b0}}, vtx, flags.corner, nrm, tex, pos};
            out_last_reg <= flags.last;
            out_user_reg <= flags.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[rtl/ofip_checker.sv]
// ofip_checker: port-level checks for the face index parser
// bound to obj_face_index_parser, sees its ports only
// depends on ofip_pkg
module ofip_checker
    import ofip_pkg::*;
#(
    parameter int INDEX_BITS        = 24,
    parameter int VERTEX_COUNT_BITS = 32
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [7:0]                            s_axis_tdata,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((3*(INDEX_BITS+1)+CORNER_BITS+VERTEX_COUNT_BITS+7)/8)*8-1:0]
                                                 m_axis_tdata,
    input logic                                  m_axis_tlast,
    input logic [STATUS_BITS-1:0]                m_axis_tuser
);

    localparam int CORNER_LO = 3 * (INDEX_BITS + 1);

    // a waiting byte is held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("waiting byte changed");

    // a stalled result stays
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no byte is taken while a result waits on a stalled receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("byte taken while result stalled");

    // too few corners is only reported on the last reference of a face
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_FEW |-> m_axis_tlast)
        else $error("few-corner status without face end");

    // too many corners only from the fifth corner on
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == STATUS_MANY
            |-> m_axis_tdata[CORNER_LO+CORNER_BITS-1] == 1'b1)
        else $error("many-corner status below fifth corner");

endmodule

bind obj_face_index_parser ofip_checker #(
    .INDEX_BITS        (INDEX_BITS),
    .VERTEX_COUNT_BITS (VERTEX_COUNT_BITS)
) u_ofip_checker (.*);

[tb/testbench.sv]
// testbench: self-checking bench for obj_face_index_parser
// streams model text, predicts every reference item and checks it field by field
// depends on ofip_pkg and the obj_face_index_parser rtl
module testbench;
    import ofip_pkg::*;

    localparam int INDEX_W  = 25;
    localparam int VERTEX_W = 32;
    localparam int TDATA_W  = ((3*INDEX_W+CORNER_BITS+VERTEX_W+7)/8)*8;

    // one vertex reference as it leaves the block
    typedef struct packed {
        logic [INDEX_W-1:0]     position;
        logic [INDEX_W-1:0]     texcoord;
        logic [INDEX_W-1:0]     normal;
        logic [CORNER_BITS-1:0] corner;
        logic [VERTEX_W-1:0]    vertex;
        logic                   face_last;
        logic [STATUS_BITS-1:0] status;
    } face_ref_t;

    // line parser prediction plus queue of references still due
    class face_ref_scoreboard;
        typedef enum logic [1:0] {LINE_KEYWORD, LINE_FACE, LINE_SKIP} line_phase_t;

        face_ref_t   refs_due[$];
        int          mismatches;

        line_phase_t phase;
        bit          keyword_is_f;
        int          keyword_len;
        longint unsigned number_acc;
        int          slot;
        longint      held_pos;
        longint      held_tex;
        longint      held_nrm;
        bit          in_ref;
        bit          pend_valid;
        longint      pend_pos;
        longint      pend_tex;
        longint      pend_nrm;
        int          corner_count;
        logic [VERTEX_W-1:0] vertex_total;

        function new();
            mismatches   = 0;
            close_line();
            number_acc   = 0;
            slot         = 0;
            held_pos     = 0;
            held_tex     = -1;
            held_nrm     = -1;
            pend_pos     = -1;
            pend_tex     = -1;
            pend_nrm     = -1;
            vertex_total = '0;
        endfunction

        function void close_line();
            phase        = LINE_KEYWORD;
            keyword_is_f = 0;
            keyword_len  = 0;
            in_ref       = 0;
            pend_valid   = 0;
            corner_count = 0;
        endfunction

        function longint part_value();
            return longint'(number_acc) - 1;
        endfunction

        function void open_ref();
            in_ref     = 1;
            number_acc = 0;
            slot       = 0;
            held_pos   = 0;
            held_tex   = -1;
            held_nrm   = -1;
        endfunction

        // close the reference in progress, the open part takes the current number
        function void finish_ref(output longint p, output longint t, output longint n);
            p      = (slot == 0) ? part_value() : held_pos;
            t      = (slot == 1) ? part_value() : held_tex;
            n      = (slot == 2) ? part_value() : held_nrm;
            in_ref = 0;
        endfunction

        function void push_ref(longint p, longint t, longint n, bit is_last);
            face_ref_t r;
            r.position  = p[INDEX_W-1:0];
            r.texcoord  = t[INDEX_W-1:0];
            r.normal    = n[INDEX_W-1:0];
            r.corner    = corner_count[CORNER_BITS-1:0];
            r.vertex    = vertex_total;
            r.face_last = is_last;
            if (corner_count >= 4)
                r.status = STATUS_MANY;
            else if (is_last && corner_count < 2)
                r.status = STATUS_FEW;
            else
                r.status = STATUS_OK;
            refs_due.insert(refs_due.size(), r);
            if (corner_count < 7)
                corner_count++;
            vertex_total = vertex_total + 1'b1;
        endfunction

        // advance the prediction by one accepted text byte
        function void note_text_byte(logic [7:0] b);
            longint p, t, n;
            if (b == CHAR_NEWLINE)
            begin
                if (phase == LINE_FACE)
                begin
                    if (in_ref)
                    begin
                        finish_ref(p, t, n);
                        push_ref(p, t, n, 1'b1);
                    end
                    else if (pend_valid)
                        push_ref(pend_pos, pend_tex, pend_nrm, 1'b1);
                end
                close_line();
                return;
            end
            // keyword ends at the first space
            if (phase == LINE_KEYWORD)
            begin
                if (b == CHAR_SPACE)
                    phase = (keyword_len == 1 && keyword_is_f) ? LINE_FACE : LINE_SKIP;
                else
                begin
                    if (keyword_len == 0 && b == CHAR_F)
                        keyword_is_f = 1;
                    if (keyword_len < 2)
                        keyword_len++;
                end
                return;
            end
            if (phase != LINE_FACE)
                return;
            // digits and slashes build a reference
            if ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_SLASH)
            begin
                if (!in_ref)
                begin
                    if (pend_valid)
                    begin
                        push_ref(pend_pos, pend_tex, pend_nrm, 1'b0);
                        pend_valid = 0;
                    end
                    open_ref();
                end
                if (b == CHAR_SLASH)
                begin
                    if (slot == 0)
                        held_pos = part_value();
                    else if (slot == 1)
                        held_tex = part_value();
                    else if (slot == 2)
                        held_nrm = part_value();
                    if (slot < 3)
                        slot++;
                    number_acc = 0;
                end
                else if (slot < 3)
                begin
                    number_acc = number_acc * 10 + longint'(b - CHAR_ZERO);
                    if (number_acc > (64'd1 << (INDEX_W - 1)) - 1)
                        number_acc = (64'd1 << (INDEX_W - 1)) - 1;
                end
                return;
            end
            // any other byte ends a reference, which then waits as pending
            if (in_ref)
            begin
                finish_ref(pend_pos, pend_tex, pend_nrm);
                pend_valid = 1;
            end
        endfunction

        // compare one accepted result item with the oldest reference due
        function void check_reference(logic [TDATA_W-1:0] data, logic tlast,
                                      logic [STATUS_BITS-1:0] tuser);
            face_ref_t got, exp;
            got.position  = data[INDEX_W-1:0];
            got.texcoord  = data[2*INDEX_W-1:INDEX_W];
            got.normal    = data[3*INDEX_W-1:2*INDEX_W];
            got.corner    = data[3*INDEX_W+CORNER_BITS-1:3*INDEX_W];
            got.vertex    = data[3*INDEX_W+CORNER_BITS+VERTEX_W-1:3*INDEX_W+CORNER_BITS];
            got.face_last = tlast;
            got.status    = tuser;
            if (refs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reference: pos %0d tex %0d nrm %0d corner %0d vertex %0d",
                             $signed(got.position), $signed(got.texcoord),
                             $signed(got.normal), got.corner, got.vertex);
                return;
            end
            exp = refs_due.pop_front();
            if (got.position !== exp.position || got.texcoord !== exp.texcoord ||
                got.normal !== exp.normal || got.corner !== exp.corner ||
                got.vertex !== exp.vertex || got.face_last !== exp.face_last ||
                got.status !== exp.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp: pos %0d tex %0d nrm %0d corner %0d vertex %0d last %0b st %0d",
                             $signed(exp.position), $signed(exp.texcoord), $signed(exp.normal),
                             exp.corner, exp.vertex, exp.face_last, exp.status);
                    $display("         got: pos %0d tex %0d nrm %0d corner %0d vertex %0d last %0b st %0d",
                             $signed(got.position), $signed(got.texcoord), $signed(got.normal),
                             got.corner, got.vertex, got.face_last, got.status);
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = 8'h00;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   m_axis_tlast;
    logic [STATUS_BITS-1:0] m_axis_tuser;

    face_ref_scoreboard refs = new();
    bit send_quiet = 0;
    bit recv_quiet = 0;
    int sent_bytes = 0;

    obj_face_index_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // one text byte with a random gap in front, held until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        refs.note_text_byte(b);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drained();
        while (refs.refs_due.size() != 0)
            @(posedge clk);
    endtask

    // one index part: empty, zero, leading zeros, near saturation, huge or small
    function automatic string rand_part();
        case ($urandom_range(0, 19))
            0: return "";
            1: return "0";
            2: return $sformatf("00%0d", $urandom_range(1, 99));
            3: return $sformatf("%0d", 16777214 + $urandom_range(0, 3));
            4: return $sformatf("%0d%0d", $urandom, $urandom_range(0, 999));
            default: return $sformatf("%0d", $urandom_range(1, 999));
        endcase
    endfunction

    function automatic string rand_reference();
        string p;
        p = rand_part();
        case ($urandom_range(0, 9))
            0, 1, 2: return p;
            3, 4:    return {p, "/", rand_part()};
            5, 6:    return {p, "//", rand_part()};
            7, 8:    return {p, "/", rand_part(), "/", rand_part()};
            default: return {p, "/", rand_part(), "/", rand_part(), "/", rand_part(), "/"};
        endcase
    endfunction

    function automatic string rand_separator();
        string s;
        s = " ";
        case ($urandom_range(0, 15))
            0: s = "  ";
            1: s = "\t";
            2: s = " \r";
            3: s = ",";
            4: s[0] = 8'($urandom_range(128, 255));
            5: s[0] = 8'($urandom_range(58, 127));
            default: s = " ";
        endcase
        return s;
    endfunction

    // a face line: mostly triangles and quads, some short and some long
    function automatic string rand_face_line();
        string line;
        int    n;
        line = ($urandom_range(0, 9) == 0) ? "f  " : "f ";
        case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, 2);
            1:       n = $urandom_range(5, 10);
            default: n = $urandom_range(3, 4);
        endcase
        for (int i = 0; i < n; i++)
            line = (i == 0) ? {line, rand_reference()}
                            : {line, rand_separator(), rand_reference()};
        if ($urandom_range(0, 4) == 0)
            line = {line, rand_separator()};
        return {line, "\n"};
    endfunction

    // lines the parser must skip
    function automatic string rand_other_line();
        string kw;
        case ($urandom_range(0, 11))
            0: kw = "v";
            1: kw = "vt";
            2: kw = "vn";
            3: kw = "ff";
            4: kw = "#";
            5: kw = "";
            6: kw = "F";
            7: kw = "f1";
            8: kw = " f";
            9: return "f\n";
            10: kw = "fx";
            default: kw = "usemtl";
        endcase
        return {kw, " ", rand_reference(), " ", rand_reference(), " ", rand_reference(), "\n"};
    endfunction

    // result side: random stall before each item
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                recv_quiet = !recv_quiet;
            stall = recv_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            refs.check_reference(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // stimulus and end of run
    initial
    begin
        string line;
        bit    paused;
        int    kind;
        paused = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every reference form, empty part, zero, saturation,
        // extra slashes, short and long faces, skipped keyword forms
        send_text("f 1 2/3 4//5 6/7/8\n");
        send_text("f /5 0 16777217/16777216 1/2/3/4/5 \n");
        send_text("f 9 9\n f 1\nf\nf \n");
        send_text("f 1 2 3 4 5 6 7 8 9\n");
        wait_drained();

        // random text until about 1050 bytes went through
        while (sent_bytes < 1050)
        begin
            if (!paused && sent_bytes > 500)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                wait_drained();
                paused = 1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 72)
            begin
                line = rand_face_line();
                send_text(line);
            end
            else if (kind < 88)
                send_text(rand_other_line());
            else
            begin
                // raw noise with every byte value possible
                repeat ($urandom_range(1, 20))
                    send_byte(8'($urandom_range(0, 255)));
                send_byte(CHAR_NEWLINE);
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (refs.mismatches == 0 && refs.refs_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hard limit on run length
    initial
    begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
